// ===== design/assert_macros.svh =====
// Assertion macros shared by the escape-time pixel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, masked while arst_n is low.
`define JEP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape-time pixel: same-cycle check failed");

// Next-cycle implication, checked on clk, masked while arst_n is low.
`define JEP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape-time pixel: next-cycle check failed");

`endif

// ===== design/jep_pkg.sv =====
// Shared types and constants of the escape-time pixel block.
`default_nettype none
package jep_pkg;

	localparam int COUNT_BITS   = 16;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RE   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_IM   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONST_RE  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONST_IM  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd6;

	localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = 16'd256;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_INIT_RE  = 9'b000000010,
		ST_INIT_IM  = 9'b000000100,
		ST_INIT_SUM = 9'b000001000,
		ST_SQ_RE    = 9'b000010000,
		ST_SQ_IM    = 9'b000100000,
		ST_CROSS    = 9'b001000000,
		ST_UPDATE   = 9'b010000000,
		ST_DONE     = 9'b100000000
	} jep_state_t;

endpackage
`default_nettype wire

// ===== design/jep_if.sv =====
// Handshake channel interfaces: pixel input, count output, config writes.
`default_nettype none
interface jep_pix_if #(parameter int INDEX_BITS = 12) ();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] column;
	logic [INDEX_BITS-1:0] row;
	modport source (output valid, output column, output row, input ready);
	modport sink   (input valid, input column, input row, output ready);
endinterface

interface jep_res_if ();
	logic                            valid;
	logic                            ready;
	logic [jep_pkg::COUNT_BITS-1:0]  iter_count;
	modport source (output valid, output iter_count, input ready);
	modport sink   (input valid, input iter_count, output ready);
endinterface

interface jep_cfg_if #(parameter int DATA_WIDTH = 32) ();
	logic                             valid;
	logic                             ready;
	logic [jep_pkg::CFG_IDX_BITS-1:0] index;
	logic [DATA_WIDTH-1:0]            data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/jep_mul.sv =====
// Shared signed multiplier with registered product and shift-saturate output.
`default_nettype none
module jep_mul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 25
) (
	input  wire logic                         clk,
	input  wire logic signed [DATA_WIDTH-1:0] a,
	input  wire logic signed [DATA_WIDTH-1:0] b,
	input  wire logic                         shift_frac,
	output logic signed [DATA_WIDTH-1:0]      prod_sat
);
	localparam int PW = 2 * DATA_WIDTH;
	localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [PW-1:0] a_ext, b_ext;
	logic signed [PW-1:0] prod_q;
	logic                 frac_q;
	logic signed [PW-1:0] shifted;
	logic [DATA_WIDTH:0]  top_bits;

	assign a_ext = a;
	assign b_ext = b;

	always_ff @(posedge clk) begin
		prod_q <= a_ext * b_ext;
		frac_q <= shift_frac;
	end

	// floor shift, then clamp to the signed data range
	assign shifted  = frac_q ? (prod_q >>> FRAC_BITS) : prod_q;
	assign top_bits = shifted[PW-1:DATA_WIDTH-1];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			prod_sat = shifted[DATA_WIDTH-1:0];
		end else if (shifted[PW-1]) begin
			prod_sat = SAT_MIN;
		end else begin
			prod_sat = SAT_MAX;
		end
	end
endmodule
`default_nettype wire

// ===== design/julia_escape_time_pixel.sv =====
// Julia-set escape-time pixel evaluator: top level with sequencer and config.
// Flow: an accepted pixel runs INIT_RE, INIT_IM, INIT_SUM, n iterations, then DONE, with
//   n = iterations run (0 when max_iter is 0); DONE waits while a result is still held.
// Throughput: one pixel at a time; the next input is taken once back in ST_IDLE; each
//   iteration: SQ_RE, SQ_IM, CROSS (re*re, im*im, re*im via the shared multiplier), UPDATE.
// Reset (arst_n low, async): sequencer idle, no result pending, config registers
//   zero except max_iter = 256.
`default_nettype none
`include "assert_macros.svh"
module julia_escape_time_pixel #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 25,
	parameter int INDEX_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jep_pix_if.sink    pix,
	jep_res_if.source  res,
	jep_cfg_if.sink    cfg
);
	localparam int CB = jep_pkg::COUNT_BITS;
	localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	// escape threshold 16.0, clamped when it does not fit the format
	localparam logic signed [DATA_WIDTH-1:0] THR =
		(FRAC_BITS + 4 >= DATA_WIDTH - 1) ? SAT_MAX : (DATA_WIDTH'(16) << FRAC_BITS);

	function automatic logic signed [DATA_WIDTH-1:0] sat_add(
		input logic signed [DATA_WIDTH-1:0] x,
		input logic signed [DATA_WIDTH-1:0] y
	);
		logic [DATA_WIDTH:0] s;
		s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
		end
		return s[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
		input logic signed [DATA_WIDTH-1:0] x,
		input logic signed [DATA_WIDTH-1:0] y
	);
		logic [DATA_WIDTH:0] s;
		s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			return s[DATA_WIDTH] ? SAT_MIN : SAT_MAX;
		end
		return s[DATA_WIDTH-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic signed [DATA_WIDTH-1:0] origin_re_q, origin_im_q, const_re_q, const_im_q;
	logic [DATA_WIDTH-2:0]        step_re_q, step_im_q;
	logic [CB-1:0]                max_iter_q;

	// writes must only be issued while idle (the block does not enforce it); the port is always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= '0;
			origin_im_q <= '0;
			step_re_q   <= '0;
			step_im_q   <= '0;
			const_re_q  <= '0;
			const_im_q  <= '0;
			max_iter_q  <= jep_pkg::MAX_ITER_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				jep_pkg::CFG_ORIGIN_RE: origin_re_q <= cfg.data;
				jep_pkg::CFG_ORIGIN_IM: origin_im_q <= cfg.data;
				jep_pkg::CFG_STEP_RE:   step_re_q   <= cfg.data[DATA_WIDTH-2:0];
				jep_pkg::CFG_STEP_IM:   step_im_q   <= cfg.data[DATA_WIDTH-2:0];
				jep_pkg::CFG_CONST_RE:  const_re_q  <= cfg.data;
				jep_pkg::CFG_CONST_IM:  const_im_q  <= cfg.data;
				jep_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg.data[CB-1:0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	jep_pkg::jep_state_t state_q;

	logic [INDEX_BITS-1:0]        col_q, row_q;
	logic signed [DATA_WIDTH-1:0] re_q, im_q, aa_q, diff_q;
	logic                         inside_q;
	logic [CB-1:0]                count_q;
	logic [CB-1:0]                count_inc;
	logic                         res_valid_q;
	logic [CB-1:0]                res_count_q;

	// shared multiplier operands, steered by the sequencer
	logic signed [DATA_WIDTH-1:0] mul_a, mul_b, prod_sat;
	logic                         mul_frac;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_frac = 1'b0;
		unique case (state_q)
			jep_pkg::ST_INIT_RE: begin
				mul_a = DATA_WIDTH'(col_q);
				mul_b = {1'b0, step_re_q};
			end
			jep_pkg::ST_INIT_IM: begin
				mul_a = DATA_WIDTH'(row_q);
				mul_b = {1'b0, step_im_q};
			end
			jep_pkg::ST_SQ_RE: begin
				mul_a    = re_q;
				mul_b    = re_q;
				mul_frac = 1'b1;
			end
			jep_pkg::ST_SQ_IM: begin
				mul_a    = im_q;
				mul_b    = im_q;
				mul_frac = 1'b1;
			end
			jep_pkg::ST_CROSS: begin
				mul_a    = re_q;
				mul_b    = im_q;
				mul_frac = 1'b1;
			end
			default: ;
		endcase
	end

	jep_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk        (clk),
		.a          (mul_a),
		.b          (mul_b),
		.shift_frac (mul_frac),
		.prod_sat   (prod_sat)
	);

	assign count_inc     = count_q + 1'b1;
	assign pix.ready     = (state_q == jep_pkg::ST_IDLE);
	assign res.valid     = res_valid_q;
	assign res.iter_count = res_count_q;

	// control: state, count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jep_pkg::ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// in ST_DONE the reload below decides the valid bit instead
			if (res_valid_q && res.ready && state_q != jep_pkg::ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				jep_pkg::ST_IDLE: begin
					if (pix.valid) begin
						count_q <= '0;
						state_q <= jep_pkg::ST_INIT_RE;
					end
				end
				jep_pkg::ST_INIT_RE:  state_q <= jep_pkg::ST_INIT_IM;
				jep_pkg::ST_INIT_IM:  state_q <= jep_pkg::ST_INIT_SUM;
				jep_pkg::ST_INIT_SUM: begin
					// a zero limit runs no iteration at all
					state_q <= (max_iter_q == '0) ? jep_pkg::ST_DONE : jep_pkg::ST_SQ_RE;
				end
				jep_pkg::ST_SQ_RE:    state_q <= jep_pkg::ST_SQ_IM;
				jep_pkg::ST_SQ_IM:    state_q <= jep_pkg::ST_CROSS;
				jep_pkg::ST_CROSS:    state_q <= jep_pkg::ST_UPDATE;
				jep_pkg::ST_UPDATE: begin
					if (inside_q) begin
						count_q <= count_inc;
					end
					if (!inside_q || count_inc == max_iter_q) begin
						state_q <= jep_pkg::ST_DONE;
					end else begin
						state_q <= jep_pkg::ST_SQ_RE;
					end
				end
				jep_pkg::ST_DONE: begin
					// wait for the output register to free up
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= jep_pkg::ST_IDLE;
					end
				end
				default: state_q <= jep_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			jep_pkg::ST_IDLE: begin
				if (pix.valid) begin
					col_q <= pix.column;
					row_q <= pix.row;
				end
			end
			jep_pkg::ST_INIT_IM:  re_q <= sat_add(origin_re_q, prod_sat);
			jep_pkg::ST_INIT_SUM: im_q <= sat_add(origin_im_q, prod_sat);
			jep_pkg::ST_SQ_IM:    aa_q <= prod_sat;
			jep_pkg::ST_CROSS: begin
				// prod_sat holds im^2 here; test uses |z|^2 before the update
				diff_q   <= sat_sub(aa_q, prod_sat);
				inside_q <= (sat_add(aa_q, prod_sat) <= THR);
			end
			jep_pkg::ST_UPDATE: begin
				// prod_sat holds re*im here
				re_q <= sat_add(diff_q, const_re_q);
				im_q <= sat_add(sat_add(prod_sat, prod_sat), const_im_q);
			end
			jep_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					res_count_q <= (count_q == '0) ? max_iter_q : count_q;
				end
			end
			default: ;
		endcase
	end

	// ---------------- assertions ----------------
	`JEP_ASSERT_NEXT(a_start_init, pix.valid && pix.ready, state_q == jep_pkg::ST_INIT_RE)
	`JEP_ASSERT_NOW(a_count_below_limit, state_q == jep_pkg::ST_UPDATE, count_q < max_iter_q)
	`JEP_ASSERT_NOW(a_result_nonzero, res_valid_q && max_iter_q != '0, res_count_q != '0)
	`JEP_ASSERT_NEXT(a_done_loads, state_q == jep_pkg::ST_DONE && !res_valid_q,
		res_valid_q && state_q == jep_pkg::ST_IDLE)
endmodule
`default_nettype wire

// ===== test/escape_count_checker.sv =====
// Checker for the escape-time pixel block: register shadow, count prediction, compare.
module escape_count_checker #(
	parameter int DW = 32,
	parameter int FB = 25,
	parameter int IB = 12
) (
	input  logic clk,
	input  logic arst_n,
	jep_pix_if   pix,
	jep_res_if   res,
	jep_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   checked
);
	import jep_pkg::*;

	localparam longint FX_MAX = (longint'(1) <<< (DW - 1)) - 1;
	localparam longint FX_MIN = -FX_MAX - 1;
	// escape radius 4, i.e. |z|^2 <= 16.0; clipped if 16.0 does not fit the format
	localparam longint ESC_LIMIT = (FB + 4 >= DW - 1) ? FX_MAX : (longint'(16) <<< FB);

	typedef struct {
		logic [COUNT_BITS-1:0] count;
		logic [IB-1:0]         column;
		logic [IB-1:0]         row;
	} pixel_count_t;

	longint                org_re, org_im, stp_re, stp_im, c_re, c_im;
	logic [COUNT_BITS-1:0] iter_limit;
	pixel_count_t          pending_counts [$];

	function automatic longint fx_sat(input longint v);
		if (v > FX_MAX)
			return FX_MAX;
		if (v < FX_MIN)
			return FX_MIN;
		return v;
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		return fx_sat(a + b);
	endfunction

	function automatic longint fx_sub(input longint a, input longint b);
		return fx_sat(a - b);
	endfunction

	// exact product, floor shift, then clip
	function automatic longint fx_mul(input longint a, input longint b, input int sh);
		longint p;
		p = a * b;
		return fx_sat(p >>> sh);
	endfunction

	function automatic logic [COUNT_BITS-1:0] escape_count(input logic [IB-1:0] col,
			input logic [IB-1:0] rw);
		longint      re, im, aa, bb, ab2, col_w, row_w;
		int unsigned n, k;
		logic        bounded;
		col_w = col;
		row_w = rw;
		re = fx_add(org_re, fx_mul(col_w, stp_re, 0));
		im = fx_add(org_im, fx_mul(row_w, stp_im, 0));
		n = 0;
		for (k = 0; k < iter_limit; k++) begin
			aa = fx_mul(re, re, FB);
			bb = fx_mul(im, im, FB);
			ab2 = fx_add(fx_mul(re, im, FB), fx_mul(re, im, FB));
			bounded = fx_add(aa, bb) <= ESC_LIMIT;
			re = fx_add(fx_sub(aa, bb), c_re);
			im = fx_add(ab2, c_im);
			if (!bounded)
				break;
			n++;
		end
		if (n == 0)
			n = iter_limit;
		return COUNT_BITS'(n);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want,
			input int col, input int rw);
		$display("checker: %s: got %0d, expected %0d (column %0d, row %0d)",
			what, got, want, col, rw);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_count_t want;
		if (!arst_n) begin
			org_re = 0;
			org_im = 0;
			stp_re = 0;
			stp_im = 0;
			c_re = 0;
			c_im = 0;
			iter_limit = MAX_ITER_RESET;
			pending_counts.delete();
			pending = 0;
		end else begin
			// results first, so a pixel taken on this edge is never matched
			if (res.valid && res.ready) begin
				if (pending_counts.size() == 0) begin
					report_mismatch("count with no pixel outstanding", res.iter_count, 0, 0, 0);
				end else begin
					want = pending_counts.pop_front();
					checked++;
					if (res.iter_count !== want.count)
						report_mismatch("iter_count", res.iter_count, want.count,
							want.column, want.row);
				end
			end
			if (pix.valid && pix.ready) begin
				want.count = escape_count(pix.column, pix.row);
				want.column = pix.column;
				want.row = pix.row;
				pending_counts.push_back(want);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_ORIGIN_RE: org_re = longint'($signed(cfg.data));
				CFG_ORIGIN_IM: org_im = longint'($signed(cfg.data));
				CFG_STEP_RE:   stp_re = longint'(cfg.data[DW-2:0]);
				CFG_STEP_IM:   stp_im = longint'(cfg.data[DW-2:0]);
				CFG_CONST_RE:  c_re = longint'($signed(cfg.data));
				CFG_CONST_IM:  c_im = longint'($signed(cfg.data));
				CFG_MAX_ITER:  iter_limit = cfg.data[COUNT_BITS-1:0];
				default: ;
				endcase
			end
			pending = pending_counts.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the escape-time pixel block: stimulus, idling, verdict.
module tb_top;
	import jep_pkg::*;

	localparam int DW = 32;
	localparam int FB = 25;
	localparam int IB = 12;
	localparam int NUM_REGS = 7;
	// index with no register behind it; writes there must be dropped
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = '1;
	localparam int ONE = 1 << FB;             // 1.0 in the data format
	localparam logic [DW-1:0] FX_MAX_WORD = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] FX_MIN_WORD = {1'b1, {(DW-1){1'b0}}};
	localparam int RANDOM_ITEMS = 1700;
	localparam int LONG_HOLD = 400;           // cycles the count side refuses results
	localparam int SETTLE = 16;               // margin once nothing is outstanding
	localparam int END_SETTLE = 64;           // watch for stray counts at the end

	// one full register setting, as raw write words
	typedef struct {
		logic [DW-1:0] origin_re;
		logic [DW-1:0] origin_im;
		logic [DW-1:0] step_re;
		logic [DW-1:0] step_im;
		logic [DW-1:0] const_re;
		logic [DW-1:0] const_im;
		logic [DW-1:0] max_iter;
	} julia_view_t;

	logic clk = 1'b0;
	logic arst_n;

	int errors;
	int pending;
	int checked;
	int items_sent;
	int settings;
	int tx_idle;
	int rx_idle;
	bit hold_req;
	int hold_left;

	jep_pix_if #(.INDEX_BITS(IB)) pix ();
	jep_res_if                    res ();
	jep_cfg_if #(.DATA_WIDTH(DW)) cfg ();

	julia_escape_time_pixel #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB),
		.INDEX_BITS(IB)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.res   (res),
		.cfg   (cfg)
	);

	escape_count_checker #(
		.DW(DW),
		.FB(FB),
		.IB(IB)
	) checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg),
		.errors (errors),
		.pending(pending),
		.checked(checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Count side. Stalls at random by rx_idle percent; on request it holds off
	// while hold_left counts down from LONG_HOLD, so the block backs up and refuses pixels.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else begin
				res.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Timeout guard, far beyond the slowest legal run (one 65535-iteration pixel
	// plus ~1700 pixels of up to 200 iterations with stalls on both sides).
	initial begin
		#200_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Called right after a falling edge; returns right after a falling edge.
	// Valid is only lowered in the idle loop or by wait_idle, so a back-to-back pixel keeps
	// valid high without a second assignment in the same step.
	task automatic send_pixel(input logic [IB-1:0] col, input logic [IB-1:0] rw);
		while ($urandom_range(99) < tx_idle) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.column <= col;
		pix.row <= rw;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Sender pause: nothing offered until every count has come back.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain, optionally poke the unused index, then write all registers, starting at a random one.
	task automatic apply_view(input julia_view_t v, input bit poke_unused);
		logic [CFG_IDX_BITS-1:0] idx_list [NUM_REGS];
		logic [DW-1:0]           word [NUM_REGS];
		int                      first;
		int                      j;
		idx_list = '{CFG_ORIGIN_RE, CFG_ORIGIN_IM, CFG_STEP_RE, CFG_STEP_IM,
			CFG_CONST_RE, CFG_CONST_IM, CFG_MAX_ITER};
		word = '{v.origin_re, v.origin_im, v.step_re, v.step_im,
			v.const_re, v.const_im, v.max_iter};
		first = $urandom_range(NUM_REGS - 1);
		wait_idle();
		if (poke_unused)
			write_reg(CFG_UNUSED, $urandom());
		for (int i = 0; i < NUM_REGS; i++) begin
			j = (first + i) % NUM_REGS;
			write_reg(idx_list[j], word[j]);
		end
		cfg.valid <= 1'b0;
		settings++;
	endtask

	// Mostly full-range indexes, with the frame edges now and then.
	function automatic logic [IB-1:0] pick_index();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return IB'($urandom());
	endfunction

	function automatic julia_view_t make_view();
		julia_view_t v;
		if ($urandom_range(3) == 0) begin
			// arbitrary words: mostly clipped starts that leave on the first test
			v.origin_re = $urandom();
			v.origin_im = $urandom();
			v.step_re = $urandom();
			v.step_im = $urandom();
			v.const_re = $urandom();
			v.const_im = $urandom();
			v.max_iter = {16'($urandom()), 16'($urandom_range(1, 200))};
		end else begin
			// a window around the interesting region and c in the unit square, so
			// pixels escape at all depths and some stay bounded
			v.origin_re = DW'(int'($urandom_range(0, ONE)) - 5 * ONE / 2);
			v.origin_im = DW'(int'($urandom_range(0, ONE)) - 3 * ONE / 2);
			v.step_re = {1'($urandom()), 31'($urandom_range(0, 3 * ONE / 2048))};
			v.step_im = {1'($urandom()), 31'($urandom_range(0, 3 * ONE / 2048))};
			v.const_re = DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
			v.const_im = DW'(int'($urandom_range(0, 2 * ONE)) - ONE);
			v.max_iter = {16'($urandom()), 16'($urandom_range(1, 40))};
		end
		return v;
	endfunction

	task automatic directed_cases();
		julia_view_t v;
		// reset values: start and c both zero, so the orbit sits at 0 for 256 rounds
		send_pixel('0, '0);
		send_pixel('1, '1);

		// max_iter of zero (junk above bit 15): no round runs, count 0
		v = '{default: '0};
		v.step_re = DW'(ONE);
		v.step_im = DW'(ONE);
		v.max_iter = 32'hABCD_0000;
		apply_view(v, 1'b1);
		send_pixel('0, '0);
		send_pixel('1, 12'd7);

		// single round: start past radius 4 gives a zero count, reported as 1
		v.max_iter = 1;
		v.step_re = DW'(5 * ONE);
		v.step_im = '0;
		apply_view(v, 1'b0);
		send_pixel('0, '0);
		send_pixel(12'd1, '1);

		// |z|^2 of exactly 16 still counts, one LSB further out escapes at once
		v = '{default: '0};
		v.origin_re = DW'(4 * ONE);
		v.step_re = 1;
		v.step_im = 1;
		v.max_iter = 10;
		apply_view(v, 1'b0);
		send_pixel('0, '0);
		send_pixel(12'd1, '0);
		send_pixel('0, 12'd1);

		// same edge on the negative imaginary side
		v.origin_re = '0;
		v.origin_im = DW'(-4 * ONE - 1);
		apply_view(v, 1'b0);
		send_pixel('0, '0);
		send_pixel('0, 12'd1);

		// clipped everything: extreme origins, full step (bit 31 masked off), extreme c
		v.origin_re = FX_MAX_WORD;
		v.origin_im = FX_MIN_WORD;
		v.step_re = '1;
		v.step_im = FX_MIN_WORD;
		v.const_re = FX_MIN_WORD;
		v.const_im = FX_MAX_WORD;
		v.max_iter = 5;
		apply_view(v, 1'b0);
		send_pixel('1, '1);
		send_pixel('0, '0);
		send_pixel('1, '0);
		send_pixel('0, '1);

		// index*step clips to max first, then the most negative origin pulls it to -1 LSB
		v.origin_re = FX_MIN_WORD;
		v.origin_im = '0;
		v.step_re = FX_MAX_WORD;
		v.step_im = '0;
		apply_view(v, 1'b0);
		send_pixel('1, '0);
		send_pixel('0, '0);
		send_pixel(12'd1, '1);

		// full 16-bit count: origin stays put for 65535 rounds; column 1 escapes
		v = '{default: '0};
		v.step_re = DW'(5 * ONE);
		v.max_iter = '1;
		apply_view(v, 1'b0);
		send_pixel('0, '0);
		send_pixel(12'd1, '0);
	endtask

	task automatic random_cases();
		julia_view_t v;
		int          batch;
		int          sent;
		for (int mode = 0; mode < 3; mode++) begin
			// idling mix: sender-light/receiver-heavy, the reverse, then none
			case (mode)
			0: begin
				tx_idle = 31;
				rx_idle = 46;
			end
			1: begin
				tx_idle = 46;
				rx_idle = 31;
			end
			default: begin
				tx_idle = 0;
				rx_idle = 0;
			end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				v = make_view();
				apply_view(v, $urandom_range(7) == 0);
				batch = $urandom_range(20, 60);
				// first batch of the first mix: count side stops for a long time
				// while pixels keep coming, so the block fills and stalls its input
				if (mode == 0 && sent == 0)
					hold_req = 1'b1;
				for (int i = 0; i < batch; i++) begin
					// mid-batch, once: hold pixels back until every count is in
					if (mode == 1 && sent == 0 && i == batch / 2)
						wait_idle();
					send_pixel(pick_index(), pick_index());
				end
				sent += batch;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.column = '0;
		pix.row = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_ORIGIN_RE;
		cfg.data = '0;
		tx_idle = 31;
		rx_idle = 46;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_cases();
		random_cases();

		// all in, then a quiet stretch to catch any stray count
		wait_idle();
		repeat (END_SETTLE) @(negedge clk);

		$display("tb_top: %0d pixels under %0d register settings, %0d counts compared",
			items_sent, settings, checked);
		$display("tb_top: max_iter 0/1/65535, clipped and radius-4 starts, stalls on both sides");
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/jep_pkg.sv
design/jep_if.sv
design/jep_mul.sv
design/julia_escape_time_pixel.sv
test/escape_count_checker.sv
test/tb_top.sv
